// ===== hw/rtl/pfba_pkg.sv =====
// pfba_pkg: shared types and constants of the page frame bitmap allocator
// beat structs, controller/datapath command and status groups, defaults
// no dependencies
package pfba_pkg;

  localparam int MaxFramesDef = 32768;
  localparam int WordBitsDef  = 32;

  localparam int CfgW       = 16;
  localparam int PageAddrW  = 32;
  localparam int PageCountW = 16;
  localparam int FrameAddrW = 27;
  localparam int PageShift  = 12;

  localparam logic [CfgW-1:0] FrameCountReset = 16'd32768;

  // operation codes
  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  typedef struct packed {
    logic                  operation;
    logic [PageAddrW-1:0]  page_address;
    logic [PageCountW-1:0] page_count;
  } in_item_t;

  typedef struct packed {
    logic [FrameAddrW-1:0] frame_address;
    logic                  ok;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic clear_wr;
    logic load;
    logic set_base;
    logic pend_plain;
    logic rd;
    logic check;
    logic advance;
    logic res_load;
  } pfba_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_last;
    logic empty;
    logic is_free;
    logic found;
    logic last_word;
  } pfba_status_t;

endpackage

// ===== hw/rtl/pfba_dp.sv =====
// pfba_dp: datapath of the page frame bitmap allocator
// bitmap memory, search hint, range and word walk registers, result register
// depends on pfba_pkg
module pfba_dp #(
  parameter int MAX_FRAMES = pfba_pkg::MaxFramesDef,
  parameter int WORD_BITS  = pfba_pkg::WordBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pfba_pkg::pfba_cmd_t        cmd_i,
  output pfba_pkg::pfba_status_t     status_o,
  input  pfba_pkg::in_item_t         in_item_i,
  input  logic [pfba_pkg::CfgW-1:0]  frame_count_i,
  output pfba_pkg::out_item_t        out_item_o
);
  import pfba_pkg::*;

  localparam int WordCount = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW = (WordCount > 1) ? $clog2(WordCount) : 1;
  localparam int FW = $clog2(MAX_FRAMES);
  localparam int LW = $clog2(MAX_FRAMES + 1);
  localparam int BW = $clog2(WORD_BITS);
  localparam int OW = $clog2(WORD_BITS + 1);
  localparam int SH = FW + $clog2(WORD_BITS);
  // rounded-up reciprocal, exact quotient for any FW-bit dividend
  localparam longint unsigned Recip =
    ((longint'(1) << SH) + longint'(WORD_BITS) - 1) / longint'(WORD_BITS);
  localparam int RW = $clog2(Recip + 1);
  localparam int PW = FW + RW;
  localparam int TW = LW + PageShift;

  logic [WORD_BITS-1:0] mem [WordCount];
  logic [WORD_BITS-1:0] rdata_q;

  logic [AW-1:0] word_q, word_d;
  logic [AW-1:0] hint_word_q;
  logic [LW-1:0] hint_base_q;
  logic [BW-1:0] hint_bit_q;

  logic          op_q;
  logic [LW-1:0] lo_q, hi_q, base_q;
  logic [PW-1:0] prod_q;
  logic [FrameAddrW-1:0] pend_addr_q;
  logic          pend_ok_q;
  out_item_t     res_q;

  logic [LW-1:0] limit;
  logic [LW-1:0] lo_d, hi_d, base_d;
  logic [PW-1:0] prod_d;
  logic [AW-1:0] quot;
  logic          start_in;
  logic [PageAddrW:0] end_full;

  logic [LW-1:0] lo_diff, hi_diff;
  logic [OW-1:0] lo_off, hi_off;
  logic [WORD_BITS-1:0] in_mask, cand, pick;
  logic [BW-1:0] idx;
  logic          found;
  logic [LW-1:0] frame;
  logic [TW-1:0] frame_bytes;
  logic          we;
  logic [WORD_BITS-1:0] wdata;

  // active frame count saturates at the bitmap size
  always_comb begin
    if (32'(frame_count_i) > 32'(MAX_FRAMES)) begin
      limit = LW'(MAX_FRAMES);
    end else begin
      limit = LW'(frame_count_i);
    end
  end

  // range setup at item accept
  always_comb begin
    start_in = in_item_i.page_address < 32'(limit);
    end_full = {1'b0, in_item_i.page_address} + 33'(in_item_i.page_count);
    prod_d   = PW'(in_item_i.page_address[FW-1:0]) * PW'(Recip);
    if (in_item_i.operation == OpFree) begin
      lo_d = start_in ? LW'(in_item_i.page_address) : limit;
      hi_d = (end_full > 33'(limit)) ? limit : LW'(end_full);
    end else begin
      lo_d = hint_base_q + LW'(hint_bit_q);
      hi_d = limit;
    end
    quot   = AW'(prod_q >> SH);
    base_d = LW'(int'(quot) * WORD_BITS);
  end

  // per-word mask of frames inside [lo, hi)
  always_comb begin
    lo_diff = lo_q - base_q;
    hi_diff = hi_q - base_q;
    lo_off  = (lo_q > base_q) ? OW'(lo_diff) : '0;
    hi_off  = (int'(hi_diff) >= WORD_BITS) ? OW'(WORD_BITS) : OW'(hi_diff);
    for (int b = 0; b < WORD_BITS; b++) begin
      in_mask[b] = (OW'(b) >= lo_off) && (OW'(b) < hi_off);
    end
    cand  = in_mask & ~rdata_q;
    found = |cand;
    pick  = cand & (~cand + WORD_BITS'(1));
    idx   = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (cand[b]) begin
        idx = BW'(b);
      end
    end
    frame       = base_q + LW'(idx);
    frame_bytes = {frame, {PageShift{1'b0}}};
  end

  assign status_o.clear_last = (word_q == AW'(WordCount - 1));
  assign status_o.empty      = (lo_q >= hi_q);
  assign status_o.is_free    = (op_q == OpFree);
  assign status_o.found      = found;
  assign status_o.last_word  =
    ({1'b0, base_q} + (LW+1)'(WORD_BITS)) >= {1'b0, hi_q};

  // memory write port
  always_comb begin
    we    = 1'b0;
    wdata = '0;
    if (cmd_i.clear_wr) begin
      we = 1'b1;
    end else if (cmd_i.check) begin
      if (op_q == OpFree) begin
        we    = 1'b1;
        wdata = rdata_q & ~in_mask;
      end else if (found) begin
        we    = 1'b1;
        wdata = rdata_q | pick;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[word_q] <= wdata;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem[word_q];
    end
  end

  always_comb begin
    word_d = word_q;
    if (cmd_i.clear_wr || cmd_i.advance) begin
      word_d = word_q + AW'(1);
    end else if (cmd_i.load && in_item_i.operation == OpAlloc) begin
      word_d = hint_word_q;
    end else if (cmd_i.set_base) begin
      word_d = quot;
    end
  end

  // control state: walk pointer and search hint
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q      <= '0;
      hint_word_q <= '0;
      hint_base_q <= '0;
      hint_bit_q  <= '0;
      op_q        <= OpAlloc;
    end else begin
      word_q <= word_d;
      if (cmd_i.load) begin
        op_q <= in_item_i.operation;
      end
      if (cmd_i.check && op_q == OpAlloc && found) begin
        hint_word_q <= word_q;
        hint_base_q <= base_q;
        hint_bit_q  <= idx;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      lo_q   <= lo_d;
      hi_q   <= hi_d;
      prod_q <= prod_d;
      if (in_item_i.operation == OpAlloc) begin
        base_q <= hint_base_q;
      end
    end else if (cmd_i.set_base) begin
      base_q <= base_d;
    end else if (cmd_i.advance) begin
      base_q <= base_q + LW'(WORD_BITS);
    end
    if (cmd_i.pend_plain) begin
      pend_addr_q <= '0;
      pend_ok_q   <= (op_q == OpFree);
    end else if (cmd_i.check) begin
      if (op_q == OpAlloc && found) begin
        pend_addr_q <= FrameAddrW'(frame_bytes);
        pend_ok_q   <= 1'b1;
      end else begin
        pend_addr_q <= '0;
        pend_ok_q   <= (op_q == OpFree);
      end
    end
    if (cmd_i.res_load) begin
      res_q.frame_address <= pend_addr_q;
      res_q.ok            <= pend_ok_q;
    end
  end

  assign out_item_o = res_q;

endmodule

// ===== hw/rtl/pfba_ctrl.sv =====
// pfba_ctrl: controller state machine of the page frame bitmap allocator
// sequences the clearing pass, the word walk and the result beat
// depends on pfba_pkg
module pfba_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  input  pfba_pkg::pfba_status_t status_i,
  output pfba_pkg::pfba_cmd_t    cmd_o
);
  import pfba_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PREP,
    S_READ,
    S_CHECK,
    S_FINISH
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   accept;
  logic   slot_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_CLEAR: cmd_o.clear_wr = 1'b1;
      S_IDLE:  cmd_o.load     = accept;
      S_PREP: begin
        if (status_i.empty) begin
          cmd_o.pend_plain = 1'b1;
        end else if (status_i.is_free) begin
          cmd_o.set_base = 1'b1;
        end
      end
      S_READ: cmd_o.rd = 1'b1;
      S_CHECK: begin
        cmd_o.check   = 1'b1;
        cmd_o.advance = !(status_i.found && !status_i.is_free) && !status_i.last_word;
      end
      S_FINISH: cmd_o.res_load = slot_free;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.res_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          if (status_i.clear_last) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state_q <= S_PREP;
          end
        end
        S_PREP: begin
          if (status_i.empty) begin
            state_q <= S_FINISH;
          end else begin
            state_q <= S_READ;
          end
        end
        S_READ: state_q <= S_CHECK;
        S_CHECK: begin
          if (cmd_o.advance) begin
            state_q <= S_READ;
          end else begin
            state_q <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (slot_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/page_frame_bitmap_allocator.sv =====
// page_frame_bitmap_allocator: top level of the page frame bitmap allocator
// holds the frame count register and joins pfba_ctrl and pfba_dp
// depends on pfba_pkg, pfba_ctrl, pfba_dp
//
//   channel  direction  handshake           beat
//   in       input      in_valid_i/stall_o  in_item_i  (operation, page_address, page_count)
//   out      output     out_valid_o/stall_i out_item_o (frame_address, ok)
//   cfg      input      cfg_valid_i/ready_o cfg_data_i (frame_count)
//
// allocate: scans bitmap words from the hint word on the single-port bitmap
//   memory; each word is read, then checked and written back
// free: reads, clears and writes back each bitmap word the run touches, same memory port;
//   an empty run, or an allocation hint at or past the frame count, skips the word walk
// after reset a clearing pass writes every bitmap word (1024 words at the default size);
//   in_stall_o stays high meanwhile, cfg is taken
// one item at a time; a new item is taken while a result beat still waits,
//   and that item's result holds in the datapath until out_stall_i drops
module page_frame_bitmap_allocator #(
  parameter int MAX_FRAMES = pfba_pkg::MaxFramesDef,
  parameter int WORD_BITS  = pfba_pkg::WordBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  pfba_pkg::in_item_t        in_item_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output pfba_pkg::out_item_t       out_item_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [pfba_pkg::CfgW-1:0] cfg_data_i
);
  import pfba_pkg::*;

  logic [CfgW-1:0] frame_count_q;
  pfba_cmd_t       cmd;
  pfba_status_t    status;

  // frame count register, always ready; an item in work keeps the range
  // bounds it latched at accept
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= FrameCountReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      frame_count_q <= cfg_data_i;
    end
  end

  // state machine: clearing pass, walk sequencing, result beat
  pfba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // bitmap, hint, range masks and result register
  pfba_dp #(
    .MAX_FRAMES (MAX_FRAMES),
    .WORD_BITS  (WORD_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .in_item_i     (in_item_i),
    .frame_count_i (frame_count_q),
    .out_item_o    (out_item_o)
  );

endmodule

// ===== hw/rtl/pfba_checker.sv =====
// pfba_checker: port-level assertions for the page frame bitmap allocator
// bound to page_frame_bitmap_allocator; depends on pfba_pkg
module pfba_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input pfba_pkg::in_item_t        in_item_i,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input pfba_pkg::out_item_t       out_item_o
);
  import pfba_pkg::*;

  // a stalled request beat holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_item_i))
    else $error("request beat changed while stalled");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result beat changed while stalled");

  // one item in flight: an accepted beat stalls the next cycle
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an item is in work");

  // a failed allocation reports address zero
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.ok |-> out_item_o.frame_address == '0)
    else $error("nonzero address on failed allocation");

  // frame addresses are page aligned
  a_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.frame_address[PageShift-1:0] == '0)
    else $error("frame address not page aligned");

endmodule

bind page_frame_bitmap_allocator pfba_checker u_pfba_checker (.*);

// ===== tb/sv/tb_page_frame_bitmap_allocator.sv =====
// tb_page_frame_bitmap_allocator: self-checking bench for the page frame bitmap allocator
// predicts every allocate/free beat from its own frame map and checks each result beat
// depends on pfba_pkg and page_frame_bitmap_allocator
`timescale 1ns / 100ps

module tb_page_frame_bitmap_allocator;
  import pfba_pkg::*;

  localparam int ClkHalf       = 4;
  localparam int WatchdogLimit = 20000;
  localparam int PerPhase      = 120;
  localparam int DrainCycles   = 64;

  // frame map, scan hint and frame count kept beside the block; one expected
  // result per accepted request, checked in order
  class allocation_scoreboard;
    bit              used_map [MaxFramesDef];
    int unsigned     scan_hint;
    logic [CfgW-1:0] frame_count;
    out_item_t       expected_results [$];
    int              errors;

    function new();
      scan_hint   = 0;
      frame_count = FrameCountReset;
      errors      = 0;
    endfunction

    function void set_frame_count(logic [CfgW-1:0] value);
      frame_count = value;
    endfunction

    function void note_request(in_item_t req);
      int unsigned    limit;
      int unsigned    f;
      bit             found;
      longint unsigned run_start;
      longint unsigned run_end;
      longint unsigned k;
      out_item_t      res;
      // counts above the map size saturate
      limit = (frame_count > MaxFramesDef) ? MaxFramesDef : frame_count;
      res   = '0;
      if (req.operation == OpAlloc) begin
        // first clear frame at or above the hint, below the active count
        f     = scan_hint;
        found = 1'b0;
        while (!found && f < limit) begin
          if (!used_map[f]) begin
            used_map[f]       = 1'b1;
            scan_hint         = f;
            found             = 1'b1;
            res.frame_address = FrameAddrW'(f) << PageShift;
            res.ok            = 1'b1;
          end else begin
            f++;
          end
        end
      end else begin
        // clear the run, clipped at the active count; hint untouched
        run_start = 64'(req.page_address);
        run_end   = run_start + 64'(req.page_count);
        if (run_end > limit) run_end = 64'(limit);
        for (k = run_start; k < run_end; k++) used_map[k] = 1'b0;
        res.ok = 1'b1;
      end
      expected_results.push_back(res);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result beat: frame_address %h ok %b", $time,
                 got.frame_address, got.ok);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (got.frame_address !== want.frame_address) begin
          $display("%0t frame_address mismatch: expected %h, actual %h", $time,
                   want.frame_address, got.frame_address);
          errors++;
        end
        if (got.ok !== want.ok) begin
          $display("%0t ok mismatch: expected %b, actual %b", $time, want.ok, got.ok);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            in_valid  = 1'b0;
  in_item_t        in_item   = '0;
  logic            out_stall = 1'b0;
  logic            cfg_valid = 1'b0;
  logic [CfgW-1:0] cfg_data  = '0;
  logic            in_stall;
  logic            out_valid;
  out_item_t       out_item;
  logic            cfg_ready;

  allocation_scoreboard sb = new();
  int unsigned          frame_limit = MaxFramesDef;  // active count the stimulus aims at
  bit                   steady      = 1'b0;          // no idling on either side while set
  int                   idle_cycles = 0;

  page_frame_bitmap_allocator dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  // 8 ns clock
  always begin
    #ClkHalf clk = 1'b1;
    #ClkHalf clk = 1'b0;
  end

  // monitor: every beat on every channel is seen here at the rising edge;
  // the watchdog counts edges with no beat anywhere
  always @(posedge clk) begin : monitor
    bit moved;
    moved = 1'b0;
    if (!rst_n) begin
      idle_cycles = 0;
    end else begin
      if (out_valid && !out_stall) begin
        sb.check_result(out_item);
        moved = 1'b1;
      end
      if (in_valid && !in_stall) begin
        sb.note_request(in_item);
        moved = 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        sb.set_frame_count(cfg_data);
        moved = 1'b1;
      end
      if (moved) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // result side: random stall before each beat, none in steady stretches
  initial begin : result_sink
    int n;
    forever begin
      @(negedge clk);
      n = steady ? 0 : $urandom_range(0, 15);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // one request beat; called and returns at a falling edge
  task automatic send_request(input in_item_t req);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= req;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // drop valid and wait until every expected result beat has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // frame count written only with the block idle
  task automatic write_frame_count(input logic [CfgW-1:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid   <= 1'b0;
    frame_limit = (value > MaxFramesDef) ? MaxFramesDef : value;
  endtask

  function automatic in_item_t make_request(logic op, logic [PageAddrW-1:0] addr,
                                            logic [PageCountW-1:0] count);
    in_item_t r;
    r.operation    = op;
    r.page_address = addr;
    r.page_count   = count;
    return r;
  endfunction

  // mostly allocations and short frees around the live region and the hint,
  // a few huge runs and wild addresses
  function automatic in_item_t random_request();
    in_item_t    r;
    int unsigned pick;
    r.operation    = ($urandom_range(0, 99) < 60) ? OpAlloc : OpFree;
    r.page_address = $urandom;
    r.page_count   = PageCountW'($urandom_range(0, 32768));
    if (r.operation == OpFree) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        // just above or below the hint, so freed frames get handed out again
        r.page_address = sb.scan_hint + $urandom_range(0, 40) - 8;
        r.page_count   = PageCountW'($urandom_range(0, 24));
      end else if (pick < 80) begin
        r.page_address = $urandom_range(0, frame_limit + 8);
        r.page_count   = PageCountW'($urandom_range(0, 40));
      end else if (pick < 85) begin
        r.page_address = $urandom_range(0, frame_limit);
      end
    end
    return r;
  endfunction

  initial begin : stimulus
    logic [CfgW-1:0] phase_counts [8];
    logic [CfgW-1:0] random_count;

    random_count = CfgW'($urandom_range(1, 4000));
    // shrinks below the hint, the extremes, saturation, then wide maps
    phase_counts = '{16'd200, 16'd48, 16'd1, 16'd0, 16'd65535, 16'd1000, random_count,
                     16'd32768};

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // directed: default count, frames 0,1,2 taken (frame zero gives address 0)
    repeat (3) send_request(make_request(OpAlloc, $urandom, PageCountW'($urandom)));
    send_request(make_request(OpFree, 32'd1, 16'd1));
    // already clear frame stays clear
    send_request(make_request(OpFree, 32'd1, 16'd1));
    // freed frame below the hint is skipped
    send_request(make_request(OpAlloc, 32'h0, 16'h0));
    // empty run
    send_request(make_request(OpFree, 32'd2, 16'd0));
    // run crossing the end of the map
    send_request(make_request(OpFree, 32'd32760, 16'd100));
    // widest address, run entirely outside the map
    send_request(make_request(OpFree, 32'hFFFF_FFFF, 16'd32768));
    // whole map freed, hint stays, so the next grant is the hint frame
    send_request(make_request(OpFree, 32'd0, 16'd32768));
    send_request(make_request(OpAlloc, 32'hFFFF_FFFF, 16'hFFFF));

    // hint above the shrunk count: allocation fails
    write_frame_count(16'd2);
    send_request(make_request(OpAlloc, 32'h0, 16'h0));
    send_request(make_request(OpFree, 32'd0, 16'd4));
    // zero frames: nothing to grant, nothing to free
    write_frame_count(16'd0);
    send_request(make_request(OpAlloc, 32'h0, 16'h0));
    send_request(make_request(OpFree, 32'd0, 16'd5));
    // count above the map size saturates
    write_frame_count(16'd65535);
    send_request(make_request(OpAlloc, 32'h0, 16'h0));
    send_request(make_request(OpFree, 32'd3, 16'd2));
    send_request(make_request(OpAlloc, 32'h0, 16'h0));

    // random phases, each under its own frame count
    foreach (phase_counts[p]) begin
      write_frame_count(phase_counts[p]);
      for (int n = 0; n < PerPhase; n++) begin
        if (n % 32 == 0) steady = ($urandom_range(0, 3) == 0);
        send_request(random_request());
      end
    end

    steady = 1'b0;
    drain_results();
    repeat (DrainCycles) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/pfba_pkg.sv
hw/rtl/pfba_dp.sv
hw/rtl/pfba_ctrl.sv
hw/rtl/page_frame_bitmap_allocator.sv
hw/rtl/pfba_checker.sv
tb/sv/tb_page_frame_bitmap_allocator.sv
